>>> hw/rtl/spct_pkg.sv
package spct_pkg;

    localparam int OP_W = 3;

    localparam logic [OP_W-1:0] OP_PT_CIRC   = 3'd0;
    localparam logic [OP_W-1:0] OP_CIRC_CIRC = 3'd1;
    localparam logic [OP_W-1:0] OP_PT_BOX    = 3'd2;
    localparam logic [OP_W-1:0] OP_BOX_BOX   = 3'd3;
    localparam logic [OP_W-1:0] OP_BOX_CIRC  = 3'd4;

    // how the last stage resolves the hit
    typedef struct packed {
        logic use_near;   // take the squared-distance compare
        logic strict;     // strict less for that compare
        logic flat_hit;   // hit when the compare is not used
    } spct_flags_t;

endpackage

>>> hw/rtl/spct_req_if.sv
interface spct_req_if #(
    parameter int COORD_BITS = 16
);
    logic                           valid;
    logic                           ready;
    logic [spct_pkg::OP_W-1:0]      op;
    logic signed [COORD_BITS-1:0]   ax;
    logic signed [COORD_BITS-1:0]   ay;
    logic [COORD_BITS-2:0]          a_half_w;
    logic [COORD_BITS-2:0]          a_half_h;
    logic [COORD_BITS-2:0]          a_diam;
    logic signed [COORD_BITS-1:0]   bx;
    logic signed [COORD_BITS-1:0]   by;
    logic [COORD_BITS-2:0]          b_half_w;
    logic [COORD_BITS-2:0]          b_half_h;
    logic [COORD_BITS-2:0]          b_diam;

    modport source (
        output valid, op, ax, ay, a_half_w, a_half_h, a_diam,
               bx, by, b_half_w, b_half_h, b_diam,
        input  ready
    );

    modport sink (
        input  valid, op, ax, ay, a_half_w, a_half_h, a_diam,
               bx, by, b_half_w, b_half_h, b_diam,
        output ready
    );
endinterface

>>> hw/rtl/spct_rsp_if.sv
interface spct_rsp_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (
        output valid, hit,
        input  ready
    );

    modport sink (
        input  valid, hit,
        output ready
    );
endinterface

>>> hw/rtl/shape_pair_collision_test_top.sv
// An accepted word moves through the stage 1 to stage 4 registers in turn;
// its result word leaves at rsp from stage 4. Throughput: one word per cycle
// while rsp takes words; four register stages (abs diff, compares, squaring
// multipliers, sum and compare), each stage stalls only when full. Reset
// (rst_n low, asynchronous) clears all stage valid bits; the block is empty and ready right after reset.
module shape_pair_collision_test_top #(
    parameter int COORD_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    spct_req_if.sink    req,
    spct_rsp_if.source  rsp
);

    localparam int C  = COORD_BITS;
    localparam int SQ = 2 * COORD_BITS;

    // ---------------- stage 1: differences and limits ----------------
    logic                       s1_v_reg;
    logic [spct_pkg::OP_W-1:0]  s1_op_reg;
    logic [C-1:0]               s1_mdx_reg, s1_mdx_next;
    logic [C-1:0]               s1_mdy_reg, s1_mdy_next;
    logic [C-1:0]               s1_lim_w_reg, s1_lim_w_next;
    logic [C-1:0]               s1_lim_h_reg, s1_lim_h_next;
    logic [C:0]                 s1_gw_reg, s1_gw_next;
    logic [C:0]                 s1_gh_reg, s1_gh_next;
    logic [C-1:0]               s1_d_reg, s1_d_next;

    logic                       s2_v_reg;
    logic [C-1:0]               s2_ex_reg, s2_ex_next;
    logic [C-1:0]               s2_ey_reg, s2_ey_next;
    logic [C-1:0]               s2_d_reg;
    spct_pkg::spct_flags_t      s2_flags_reg, s2_flags_next;

    logic                       s3_v_reg;
    logic [SQ-1:0]              s3_sqx_reg, s3_sqx_next;
    logic [SQ-1:0]              s3_sqy_reg, s3_sqy_next;
    logic [SQ-1:0]              s3_sqd_reg, s3_sqd_next;
    spct_pkg::spct_flags_t      s3_flags_reg;

    logic                       s4_v_reg;
    logic                       s4_hit_reg, s4_hit_next;

    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !s4_v_reg || rsp.ready;
    assign rdy3 = !s3_v_reg || rdy4;
    assign rdy2 = !s2_v_reg || rdy3;
    assign rdy1 = !s1_v_reg || rdy2;

    assign req.ready = rdy1;
    assign rsp.valid = s4_v_reg;
    assign rsp.hit   = s4_hit_reg;

    logic [C:0] dxp, dxn, dyp, dyn;

    always_comb
    begin
        dxp = {req.bx[C-1], req.bx} - {req.ax[C-1], req.ax};
        dxn = {req.ax[C-1], req.ax} - {req.bx[C-1], req.bx};
        dyp = {req.by[C-1], req.by} - {req.ay[C-1], req.ay};
        dyn = {req.ay[C-1], req.ay} - {req.by[C-1], req.by};
        s1_mdx_next = dxp[C] ? dxn[C-1:0] : dxp[C-1:0];
        s1_mdy_next = dyp[C] ? dyn[C-1:0] : dyp[C-1:0];

        case (req.op)
            spct_pkg::OP_BOX_BOX:
            begin
                s1_lim_w_next = {1'b0, req.a_half_w} + {1'b0, req.b_half_w};
                s1_lim_h_next = {1'b0, req.a_half_h} + {1'b0, req.b_half_h};
            end
            spct_pkg::OP_PT_BOX:
            begin
                s1_lim_w_next = {1'b0, req.b_half_w};
                s1_lim_h_next = {1'b0, req.b_half_h};
            end
            default:
            begin
                s1_lim_w_next = {1'b0, req.a_half_w};
                s1_lim_h_next = {1'b0, req.a_half_h};
            end
        endcase

        s1_gw_next = {1'b0, req.a_half_w, 1'b0} + {2'b00, req.b_diam};
        s1_gh_next = {1'b0, req.a_half_h, 1'b0} + {2'b00, req.b_diam};

        if (req.op == spct_pkg::OP_CIRC_CIRC)
            s1_d_next = {1'b0, req.a_diam} + {1'b0, req.b_diam};
        else
            s1_d_next = {1'b0, req.b_diam};
    end

    // ---------------- stage 2: compares, corner offsets ----------------
    logic [C:0]   diff_w, diff_h;
    logic         w_lt, h_lt, w_le, h_le, gw_ok, gh_ok, band, nz;
    logic [C-1:0] cx, cy;

    always_comb
    begin
        diff_w = {1'b0, s1_mdx_reg} - {1'b0, s1_lim_w_reg};
        diff_h = {1'b0, s1_mdy_reg} - {1'b0, s1_lim_h_reg};
        w_lt   = diff_w[C];
        h_lt   = diff_h[C];
        w_le   = w_lt || (s1_mdx_reg == s1_lim_w_reg);
        h_le   = h_lt || (s1_mdy_reg == s1_lim_h_reg);
        cx     = w_lt ? (s1_lim_w_reg - s1_mdx_reg) : diff_w[C-1:0];
        cy     = h_lt ? (s1_lim_h_reg - s1_mdy_reg) : diff_h[C-1:0];
        gw_ok  = {s1_mdx_reg, 1'b0} <= s1_gw_reg;
        gh_ok  = {s1_mdy_reg, 1'b0} <= s1_gh_reg;
        band   = w_lt || h_lt;
        nz     = (s1_mdx_reg != '0) && (s1_mdy_reg != '0);

        s2_ex_next    = s1_mdx_reg;
        s2_ey_next    = s1_mdy_reg;
        s2_flags_next = '0;

        case (s1_op_reg)
            spct_pkg::OP_PT_CIRC:
            begin
                s2_flags_next.use_near = 1'b1;
                s2_flags_next.strict   = 1'b1;
            end
            spct_pkg::OP_CIRC_CIRC:
            begin
                s2_flags_next.use_near = 1'b1;
            end
            spct_pkg::OP_PT_BOX, spct_pkg::OP_BOX_BOX:
            begin
                s2_flags_next.flat_hit = w_le && h_le;
            end
            spct_pkg::OP_BOX_CIRC:
            begin
                s2_ex_next = cx;
                s2_ey_next = cy;
                if (band)
                    s2_flags_next.flat_hit = gw_ok && gh_ok;
                else
                begin
                    // centre on an axis outside both bands: no corner, miss
                    s2_flags_next.use_near = nz;
                    s2_flags_next.strict   = 1'b1;
                end
            end
            default:
            begin
                s2_flags_next = '0;
            end
        endcase
    end

    // ---------------- stage 3: squares ----------------
    logic [SQ-1:0] ex_w, ey_w, d_w;

    always_comb
    begin
        ex_w        = SQ'(s2_ex_reg);
        ey_w        = SQ'(s2_ey_reg);
        d_w         = SQ'(s2_d_reg);
        s3_sqx_next = ex_w * ex_w;
        s3_sqy_next = ey_w * ey_w;
        s3_sqd_next = d_w * d_w;
    end

    // ---------------- stage 4: 4*dist^2 against d^2 ----------------
    logic [SQ:0]   sum_sq;
    logic [SQ+2:0] lhs, rhs;
    logic          near_lt, near_le;

    always_comb
    begin
        sum_sq  = {1'b0, s3_sqx_reg} + {1'b0, s3_sqy_reg};
        lhs     = {sum_sq, 2'b00};
        rhs     = {3'b000, s3_sqd_reg};
        near_lt = lhs < rhs;
        near_le = lhs <= rhs;
        if (s3_flags_reg.use_near)
            s4_hit_next = s3_flags_reg.strict ? near_lt : near_le;
        else
            s4_hit_next = s3_flags_reg.flat_hit;
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_v_reg <= req.valid;
            if (rdy2)
                s2_v_reg <= s1_v_reg;
            if (rdy3)
                s3_v_reg <= s2_v_reg;
            if (rdy4)
                s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_op_reg    <= req.op;
            s1_mdx_reg   <= s1_mdx_next;
            s1_mdy_reg   <= s1_mdy_next;
            s1_lim_w_reg <= s1_lim_w_next;
            s1_lim_h_reg <= s1_lim_h_next;
            s1_gw_reg    <= s1_gw_next;
            s1_gh_reg    <= s1_gh_next;
            s1_d_reg     <= s1_d_next;
        end
        if (rdy2)
        begin
            s2_ex_reg    <= s2_ex_next;
            s2_ey_reg    <= s2_ey_next;
            s2_d_reg     <= s1_d_reg;
            s2_flags_reg <= s2_flags_next;
        end
        if (rdy3)
        begin
            s3_sqx_reg   <= s3_sqx_next;
            s3_sqy_reg   <= s3_sqy_next;
            s3_sqd_reg   <= s3_sqd_next;
            s3_flags_reg <= s2_flags_reg;
        end
        if (rdy4)
            s4_hit_reg <= s4_hit_next;
    end

    // ---------------- assertions ----------------
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_v_reg |-> req.ready)
        else $error("stage 1 empty but input not ready");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> s1_v_reg)
        else $error("accepted word not held in stage 1");

    a_bad_op_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_v_reg && rdy2 && (s1_op_reg > spct_pkg::OP_BOX_CIRC))
        |=> (s2_v_reg && !s2_flags_reg.use_near && !s2_flags_reg.flat_hit))
        else $error("unused op code not forced to miss");

    a_flat_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_v_reg && rdy4 && !s3_flags_reg.use_near && !s3_flags_reg.flat_hit)
        |=> (s4_v_reg && !s4_hit_reg))
        else $error("miss flagged in stage 3 turned into hit");

endmodule

>>> bench/shape_pair_collision_test_top_tb.sv
module shape_pair_collision_test_top_tb;

    localparam int     CB         = 16;
    localparam int     OPW        = spct_pkg::OP_W;
    localparam int     CMAX       = 2**(CB-1) - 1;
    localparam int     CMIN       = -(2**(CB-1));
    localparam int     SMAX       = 2**(CB-1) - 1;
    localparam int     IDLE_LIMIT = 2000;
    localparam int     LONG_HOLD  = 80;

    // op codes that select no shape pair
    localparam logic [OPW-1:0] OP_SPARE_FIRST = OPW'(int'(spct_pkg::OP_BOX_CIRC) + 1);
    localparam logic [OPW-1:0] OP_SPARE_LAST  = '1;
    localparam logic [OPW-1:0] OP_SPARE_MID   = OPW'(int'(OP_SPARE_LAST) - 1);

    typedef struct {
        logic [OPW-1:0]         op;
        logic signed [CB-1:0]   ax;
        logic signed [CB-1:0]   ay;
        logic [CB-2:0]          a_half_w;
        logic [CB-2:0]          a_half_h;
        logic [CB-2:0]          a_diam;
        logic signed [CB-1:0]   bx;
        logic signed [CB-1:0]   by;
        logic [CB-2:0]          b_half_w;
        logic [CB-2:0]          b_half_h;
        logic [CB-2:0]          b_diam;
    } shape_pair_t;

    logic clk = 1'b0;
    logic rst_n;

    spct_req_if #(.COORD_BITS(CB)) req_ch ();
    spct_rsp_if                    rsp_ch ();

    shape_pair_collision_test_top #(.COORD_BITS(CB)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    shape_pair_t pending_pairs[$];
    bit          expected_hits[$];

    logic req_taken = 1'b0;
    logic rsp_taken = 1'b0;
    int   send_gap  = 0;
    int   recv_wait = 0;
    bit   send_calm = 1'b0;
    bit   recv_calm = 1'b0;
    int   rsp_count = 0;
    int   idle_cycles = 0;
    int   mismatches = 0;
    int   sent_total = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint gap_len(longint a, longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    // 4*dist^2 against d^2
    function automatic bit circle_reach(longint px, longint py, longint cx, longint cy,
                                        longint d, bit open_edge);
        longint dx;
        longint dy;
        longint lhs;
        dx  = 2 * gap_len(px, cx);
        dy  = 2 * gap_len(py, cy);
        lhs = dx * dx + dy * dy;
        return open_edge ? (lhs < d * d) : (lhs <= d * d);
    endfunction

    function automatic bit overlap_of(shape_pair_t w);
        longint ax, ay, bx, by, ahw, ahh, bhw, bhh, ad, bd, kx, ky;
        bit     in_x;
        bit     in_y;
        bit     hit;
        ax  = w.ax;
        ay  = w.ay;
        bx  = w.bx;
        by  = w.by;
        ahw = w.a_half_w;
        ahh = w.a_half_h;
        ad  = w.a_diam;
        bhw = w.b_half_w;
        bhh = w.b_half_h;
        bd  = w.b_diam;
        hit = 1'b0;
        case (w.op)
            spct_pkg::OP_PT_CIRC:   hit = circle_reach(ax, ay, bx, by, bd, 1'b1);
            spct_pkg::OP_CIRC_CIRC: hit = circle_reach(ax, ay, bx, by, ad + bd, 1'b0);
            spct_pkg::OP_PT_BOX:    hit = (bx - bhw <= ax) && (ax <= bx + bhw) &&
                                          (by - bhh <= ay) && (ay <= by + bhh);
            spct_pkg::OP_BOX_BOX:   hit = (gap_len(ax, bx) <= ahw + bhw) &&
                                          (gap_len(ay, by) <= ahh + bhh);
            spct_pkg::OP_BOX_CIRC:
            begin
                in_x = (ax - ahw < bx) && (bx < ax + ahw);
                in_y = (ay - ahh < by) && (by < ay + ahh);
                if (in_x || in_y)
                begin
                    hit = (2 * gap_len(bx, ax) <= 2 * ahw + bd) &&
                          (2 * gap_len(by, ay) <= 2 * ahh + bd);
                end
                else if (bx != ax && by != ay)
                begin
                    // nearest corner by quadrant
                    kx  = (bx < ax) ? ax - ahw : ax + ahw;
                    ky  = (by < ay) ? ay - ahh : ay + ahh;
                    hit = circle_reach(kx, ky, bx, by, bd, 1'b1);
                end
            end
            default:      hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic void add_pair(logic [OPW-1:0] op, int ax, int ay, int ahw, int ahh,
                                     int ad, int bx, int by, int bhw, int bhh, int bd);
        shape_pair_t w;
        w.op       = op;
        w.ax       = CB'(ax);
        w.ay       = CB'(ay);
        w.a_half_w = (CB-1)'(ahw);
        w.a_half_h = (CB-1)'(ahh);
        w.a_diam   = (CB-1)'(ad);
        w.bx       = CB'(bx);
        w.by       = CB'(by);
        w.b_half_w = (CB-1)'(bhw);
        w.b_half_h = (CB-1)'(bhh);
        w.b_diam   = (CB-1)'(bd);
        pending_pairs.push_back(w);
    endfunction

    function automatic logic signed [CB-1:0] near_coord(logic signed [CB-1:0] c, int sb);
        longint v;
        if (sb >= CB)
            return CB'($urandom);
        v = c;
        v = v + longint'($urandom_range(0, (1 << (sb + 1)) - 2)) - ((1 << sb) - 1);
        if (v > CMAX)
            v = CMAX;
        if (v < CMIN)
            v = CMIN;
        return CB'(v);
    endfunction

    function automatic logic [CB-2:0] size_draw(int sb);
        return (CB-1)'($urandom & ((1 << sb) - 1));
    endfunction

    function automatic shape_pair_t random_pair();
        shape_pair_t w;
        int          sb;
        if ($urandom_range(0, 31) == 0)
            w.op = OPW'($urandom_range(int'(OP_SPARE_FIRST), int'(OP_SPARE_LAST)));
        else
            w.op = OPW'($urandom_range(0, int'(spct_pkg::OP_BOX_CIRC)));
        sb         = $urandom_range(1, CB);
        w.ax       = CB'($urandom);
        w.ay       = CB'($urandom);
        w.bx       = near_coord(w.ax, sb);
        w.by       = near_coord(w.ay, sb);
        w.a_half_w = size_draw(sb);
        w.a_half_h = size_draw(sb);
        w.a_diam   = size_draw(sb);
        w.b_half_w = size_draw(sb);
        w.b_half_h = size_draw(sb);
        w.b_diam   = size_draw(sb);
        return w;
    endfunction

    function automatic int pause_len(bit calm);
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    always @(negedge clk)
    begin : drive_req
        shape_pair_t w;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (req_ch.valid && !req_taken)
        begin
        end
        else if (send_gap > 0)
        begin
            req_ch.valid <= 1'b0;
            send_gap     <= send_gap - 1;
        end
        else if (pending_pairs.size() > 0)
        begin
            w = pending_pairs.pop_front();
            req_ch.op       <= w.op;
            req_ch.ax       <= w.ax;
            req_ch.ay       <= w.ay;
            req_ch.a_half_w <= w.a_half_w;
            req_ch.a_half_h <= w.a_half_h;
            req_ch.a_diam   <= w.a_diam;
            req_ch.bx       <= w.bx;
            req_ch.by       <= w.by;
            req_ch.b_half_w <= w.b_half_w;
            req_ch.b_half_h <= w.b_half_h;
            req_ch.b_diam   <= w.b_diam;
            req_ch.valid    <= 1'b1;
            send_gap        <= pause_len(send_calm);
            if ($urandom_range(0, 149) == 0)
                send_calm <= !send_calm;
        end
        else
        begin
            req_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : drive_rsp_ready
        int w;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            w = recv_wait;
            if (rsp_taken)
            begin
                w = pause_len(recv_calm);
                // long back-pressure so the pipe fills and stalls req
                if (rsp_count == 400 || rsp_count == 1300)
                    w = LONG_HOLD;
                if ($urandom_range(0, 149) == 0)
                    recv_calm <= !recv_calm;
            end
            if (w > 0)
            begin
                rsp_ch.ready <= 1'b0;
                recv_wait    <= w - 1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                recv_wait    <= 0;
            end
        end
    end

    always @(posedge clk)
    begin : check_hits
        shape_pair_t seen;
        bit          want;
        req_taken <= req_ch.valid && req_ch.ready;
        rsp_taken <= rsp_ch.valid && rsp_ch.ready;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_count <= rsp_count + 1;
            if (expected_hits.size() == 0)
            begin
                $error("hit: no word expected, actual %0b", rsp_ch.hit);
                mismatches++;
            end
            else
            begin
                want = expected_hits.pop_front();
                if (rsp_ch.hit !== want)
                begin
                    $error("hit: expected %0b, actual %0b", want, rsp_ch.hit);
                    mismatches++;
                end
            end
        end
        if (req_ch.valid && req_ch.ready)
        begin
            seen.op       = req_ch.op;
            seen.ax       = req_ch.ax;
            seen.ay       = req_ch.ay;
            seen.a_half_w = req_ch.a_half_w;
            seen.a_half_h = req_ch.a_half_h;
            seen.a_diam   = req_ch.a_diam;
            seen.bx       = req_ch.bx;
            seen.by       = req_ch.by;
            seen.b_half_w = req_ch.b_half_w;
            seen.b_half_h = req_ch.b_half_h;
            seen.b_diam   = req_ch.b_diam;
            expected_hits.push_back(overlap_of(seen));
        end
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.op       = '0;
        req_ch.ax       = '0;
        req_ch.ay       = '0;
        req_ch.a_half_w = '0;
        req_ch.a_half_h = '0;
        req_ch.a_diam   = '0;
        req_ch.bx       = '0;
        req_ch.by       = '0;
        req_ch.b_half_w = '0;
        req_ch.b_half_h = '0;
        req_ch.b_diam   = '0;
        rsp_ch.ready    = 1'b0;

        add_pair(spct_pkg::OP_PT_CIRC,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(spct_pkg::OP_PT_CIRC,   0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        // point on the rim is outside
        add_pair(spct_pkg::OP_PT_CIRC,   10, 0, 0, 0, 0, 0, 0, 0, 0, 20);
        add_pair(spct_pkg::OP_PT_CIRC,   CMIN, CMIN, SMAX, SMAX, SMAX, CMAX, CMAX,
                 SMAX, SMAX, SMAX);
        // touching circles overlap
        add_pair(spct_pkg::OP_CIRC_CIRC, 0, 0, 0, 0, 10, 10, 0, 0, 0, 10);
        add_pair(spct_pkg::OP_CIRC_CIRC, 0, 0, 0, 0, 10, 11, 0, 0, 0, 10);
        add_pair(spct_pkg::OP_CIRC_CIRC, CMAX, CMAX, 0, 0, SMAX, CMIN, CMIN, 0, 0, SMAX);
        add_pair(spct_pkg::OP_CIRC_CIRC, -5, 7, 0, 0, 0, -5, 7, 0, 0, 0);
        add_pair(spct_pkg::OP_CIRC_CIRC, CMIN, CMAX, 0, 0, SMAX, CMIN, CMAX, 0, 0, SMAX);
        add_pair(spct_pkg::OP_PT_BOX,    5, 5, 0, 0, 0, 0, 0, 5, 5, 0);
        add_pair(spct_pkg::OP_PT_BOX,    6, 5, 0, 0, 0, 0, 0, 5, 5, 0);
        add_pair(spct_pkg::OP_PT_BOX,    CMIN, CMAX, 0, 0, 0, 0, 0, SMAX, SMAX, 0);
        add_pair(spct_pkg::OP_PT_BOX,    CMIN + 1, CMAX, 0, 0, 0, 0, 0, SMAX, SMAX, 0);
        add_pair(spct_pkg::OP_BOX_BOX,   0, 0, 3, 3, 0, 7, 7, 4, 4, 0);
        add_pair(spct_pkg::OP_BOX_BOX,   0, 0, 3, 3, 0, 8, 7, 4, 4, 0);
        add_pair(spct_pkg::OP_BOX_BOX,   CMIN, CMIN, SMAX, SMAX, 0, CMAX, CMAX,
                 SMAX, SMAX, 0);
        add_pair(spct_pkg::OP_BOX_CIRC,  0, 0, 10, 10, 0, 5, 14, 0, 0, 8);
        add_pair(spct_pkg::OP_BOX_CIRC,  0, 0, 10, 10, 0, 5, 14, 0, 0, 7);
        // corner test is strict
        add_pair(spct_pkg::OP_BOX_CIRC,  0, 0, 10, 10, 0, 13, 14, 0, 0, 10);
        add_pair(spct_pkg::OP_BOX_CIRC,  0, 0, 10, 10, 0, -13, -14, 0, 0, 11);
        // centre on an axis outside both bands never hits
        add_pair(spct_pkg::OP_BOX_CIRC,  0, 0, 0, 0, 0, 0, 5, 0, 0, SMAX);
        add_pair(spct_pkg::OP_BOX_CIRC,  0, 0, 0, 0, 0, 0, 0, 0, 0, SMAX);
        add_pair(spct_pkg::OP_BOX_CIRC,  0, 0, 0, 0, 0, 3, -4, 0, 0, 11);
        add_pair(spct_pkg::OP_BOX_CIRC,  CMAX, CMIN, SMAX, SMAX, SMAX, CMIN, CMAX,
                 SMAX, SMAX, SMAX);
        add_pair(OP_SPARE_FIRST, -1, -1, SMAX, SMAX, SMAX, -1, -1, SMAX, SMAX, SMAX);
        add_pair(OP_SPARE_MID, 0, 0, SMAX, SMAX, SMAX, 0, 0, SMAX, SMAX, SMAX);
        add_pair(OP_SPARE_LAST, 0, 0, SMAX, SMAX, SMAX, 0, 0, SMAX, SMAX, SMAX);
        repeat (1925)
            pending_pairs.push_back(random_pair());
        sent_total = pending_pairs.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (rsp_count == sent_total);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_hits.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> shape_pair_collision_test_top.f
hw/rtl/spct_pkg.sv
hw/rtl/spct_req_if.sv
hw/rtl/spct_rsp_if.sv
hw/rtl/shape_pair_collision_test_top.sv
bench/shape_pair_collision_test_top_tb.sv
